### design/sha1_pkg.sv
// ============================================================================
// SHA-1 hasher package
// Shared types, constants and round helpers.
// ============================================================================
`default_nettype none
package sha1_pkg;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [2:0] DIGEST_LAST = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } sha1_state_t;

    // controller -> datapath
    typedef struct packed {
        logic       load_byte;   // write byte into buffer
        logic [7:0] byte_val;
        logic       count_byte;  // bump message length
        logic       start_round; // load working vars
        logic       round_step;  // one round
        logic       finish;      // add working vars into chain
        logic       write_len;   // place bit length in words 14/15
        logic       clear;       // reset chain, position, length
    } sha1_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       block_full;  // byte position at 63: next byte fills the block
        logic [5:0] byte_pos;
        logic       rounds_done;
    } sha1_stat_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage
`default_nettype wire

### design/sha1_datapath.sv
// ============================================================================
// SHA-1 datapath
// Block buffer, message schedule window, round unit and chain registers.
// ============================================================================
`default_nettype none
module sha1_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sha1_pkg::sha1_cmd_t  cmd,
    output sha1_pkg::sha1_stat_t      stat,
    input  wire logic [2:0]           rd_idx,
    output logic [31:0]               rd_word
);
    import sha1_pkg::*;

    logic [31:0] chain_reg [5];
    logic [31:0] buf_reg [16];
    logic [5:0]  pos_reg;
    logic [63:0] count_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [6:0]  round_reg;

    logic [3:0]  widx;
    logic [1:0]  lane;
    logic [31:0] part;
    logic [31:0] f_val, k_val, w_val, w_new, t_val;
    logic [63:0] bits;

    assign widx = pos_reg[5:2];
    assign lane = pos_reg[1:0];
    assign part = {24'd0, cmd.byte_val} << {(2'd3 - lane), 3'b000};
    assign bits = {count_reg[60:0], 3'b000};

    // schedule: buffer acts as 16-word sliding window, buf_reg[0] is w[i]
    assign w_new = rotl(buf_reg[13] ^ buf_reg[8] ^ buf_reg[2] ^ buf_reg[0], 1);
    assign w_val = buf_reg[0];

    always_comb begin
        if (round_reg < 7'd20) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end else if (round_reg < 7'd40) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end else if (round_reg < 7'd60) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
    end
    assign t_val = rotl(a_reg, 5) + f_val + e_reg + k_val + w_val;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            chain_reg[0] <= H0_INIT;
            chain_reg[1] <= H1_INIT;
            chain_reg[2] <= H2_INIT;
            chain_reg[3] <= H3_INIT;
            chain_reg[4] <= H4_INIT;
            pos_reg      <= '0;
            count_reg    <= '0;
            round_reg    <= '0;
        end else begin
            if (cmd.load_byte) begin
                pos_reg <= pos_reg + 6'd1;
            end
            if (cmd.count_byte) begin
                count_reg <= count_reg + 64'd1;
            end
            if (cmd.start_round) begin
                round_reg <= '0;
            end else if (cmd.round_step) begin
                round_reg <= round_reg + 7'd1;
            end
            if (cmd.finish) begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
                chain_reg[4] <= chain_reg[4] + e_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_byte) begin
            buf_reg[widx] <= (lane == 2'd0) ? part : (buf_reg[widx] | part);
        end
        if (cmd.write_len) begin
            buf_reg[14] <= bits[63:32];
            buf_reg[15] <= bits[31:0];
        end
        if (cmd.round_step) begin
            for (int i = 0; i < 15; i++) begin
                buf_reg[i] <= buf_reg[i + 1];
            end
            buf_reg[15] <= w_new;
            a_reg <= t_val;
            b_reg <= a_reg;
            c_reg <= rotl(b_reg, 30);
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
        if (cmd.start_round) begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
    end

    assign stat.block_full  = (pos_reg == 6'd63);
    assign stat.byte_pos    = pos_reg;
    assign stat.rounds_done = (round_reg == 7'd79);
    assign rd_word = chain_reg[(rd_idx > DIGEST_LAST) ? DIGEST_LAST : rd_idx];

`ifndef SYNTHESIS
    // counter sits at 80 after the last round until the next start
    a_round_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        round_reg <= 7'd80)
        else $error("round counter past 80");
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_round && !cmd.clear |=> round_reg == 7'd0)
        else $error("round counter not restarted");
`endif
endmodule
`default_nettype wire

### design/sha1_ctrl.sv
// ============================================================================
// SHA-1 controller
// Sequences byte loads, compressions, padding and digest output.
// ============================================================================
`default_nettype none
module sha1_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [7:0]           in_byte,
    input  wire logic                 in_present,
    input  wire logic                 in_end,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2:0]                out_idx,
    output sha1_pkg::sha1_cmd_t       cmd,
    input  wire sha1_pkg::sha1_stat_t stat
);
    import sha1_pkg::*;

    sha1_state_t state_reg, state_next;
    logic        end_reg, end_next;     // message closing: pad after compress
    logic        lenb_reg, lenb_next;   // last compress was the length block
    logic        pad_reg, pad_next;     // 0x80 marker already placed
    logic [2:0]  idx_reg, idx_next;
    logic        acc;
    logic        len_slot;

    assign acc = in_valid && in_ready;
    // marker placed and position at byte 56: length goes in now
    assign len_slot = pad_reg && (stat.byte_pos == 6'd56);

    // next state
    always_comb begin
        state_next = state_reg;
        end_next   = end_reg;
        lenb_next  = lenb_reg;
        pad_next   = pad_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    end_next  = in_end;
                    lenb_next = 1'b0;
                    pad_next  = 1'b0;
                    if (in_present && stat.byte_pos == 6'd63) begin
                        state_next = ST_ROUND;
                    end else if (in_end) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                if (stat.rounds_done) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (lenb_reg) begin
                    state_next = ST_OUT;
                    idx_next   = '0;
                end else if (end_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_PAD: begin
                pad_next = 1'b1;
                if (len_slot) begin
                    state_next = ST_LEN;
                end else if (stat.block_full) begin
                    state_next = ST_ROUND;
                end
            end
            ST_LEN: begin
                state_next = ST_ROUND;
                lenb_next  = 1'b1;
            end
            ST_OUT: begin
                if (out_ready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == DIGEST_LAST) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready       = 1'b1;
                cmd.load_byte  = acc && in_present;
                cmd.count_byte = acc && in_present;
                cmd.byte_val   = in_byte;
                cmd.start_round = acc && in_present && stat.byte_pos == 6'd63;
            end
            ST_ROUND: cmd.round_step = 1'b1;
            ST_FINAL: begin
                cmd.finish = 1'b1;
            end
            ST_PAD: begin
                // first pad cycle places 0x80, then zeros up to byte 55
                cmd.byte_val    = pad_reg ? 8'h00 : PAD_BYTE;
                cmd.load_byte   = !len_slot;
                cmd.start_round = stat.block_full;
                cmd.write_len   = len_slot;
            end
            ST_LEN: begin
                cmd.start_round = 1'b1;
            end
            ST_OUT: begin
                out_valid = 1'b1;
                cmd.clear = out_ready && idx_reg == DIGEST_LAST;
            end
            default: ;
        endcase
    end

    assign out_idx = idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            end_reg   <= 1'b0;
            lenb_reg  <= 1'b0;
            pad_reg   <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            end_reg   <= end_next;
            lenb_reg  <= lenb_next;
            pad_reg   <= pad_next;
            idx_reg   <= idx_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid))
        else $error("input taken while digest pending");
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> idx_reg <= DIGEST_LAST)
        else $error("digest index out of range");
    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_ready && idx_reg == DIGEST_LAST |=> state_reg == ST_IDLE)
        else $error("no return to idle after digest");
`endif
endmodule
`default_nettype wire

### design/sha1_message_hasher.sv
// ============================================================================
// SHA-1 message hasher
// Byte-stream SHA-1 with padding and five-word digest output.
// ============================================================================
// Usage:
//   s_axis: one beat per item. tdata[7:0] = message byte, tuser[0] =
//   byte present, tlast = end of message (byte, if present, goes first).
//   m_axis: five beats per message, digest word H0 first. tdata[31:0] =
//   word, tuser[2:0] = word index, tlast on the fifth word.
// Input: byte beats are accepted back to back while idle; the 64th byte of
//   a block starts a compression (80 rounds through one shared round unit,
//   then one chain update) during which s_tready is low.
// End of message: padding runs one byte per cycle up to byte 55, plus an
//   extra compression when the 0x80 marker lands past byte 55; then the
//   length is written, the working vars are loaded and the length block
//   compression runs; digest beats follow, one per cycle while m_tready
//   is high.
// Reset: synchronous, aresetn low; chain, byte position and length return
//   to initial values. Also restored after the last digest beat.
// Stall: while m_tready is low the current digest word holds and no new
//   input is taken until all five words are delivered.
// ============================================================================
`default_nettype none
module sha1_message_hasher (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  wire logic        s_axis_tuser,  // [0] byte_present
    input  wire logic        s_axis_tlast,  // end_of_message
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // [31:0] digest_word
    output logic [2:0]       m_axis_tuser,  // [2:0] word_index
    output logic             m_axis_tlast   // last_word
);
    import sha1_pkg::*;

    sha1_cmd_t  cmd;
    sha1_stat_t stat;
    logic [2:0] idx;

    sha1_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_byte    (s_axis_tdata),
        .in_present (s_axis_tuser),
        .in_end     (s_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_idx    (idx),
        .cmd        (cmd),
        .stat       (stat)
    );

    sha1_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .rd_idx  (idx),
        .rd_word (m_axis_tdata)
    );

    assign m_axis_tuser = idx;
    assign m_axis_tlast = (idx == DIGEST_LAST);
endmodule
`default_nettype wire
